### hdl/pwm_quadrature_angle_sync_core_defines.svh
// Assertion macros shared by the checker of the angle sync core.
`ifndef PWM_QUADRATURE_ANGLE_SYNC_CORE_DEFINES_SVH
`define PWM_QUADRATURE_ANGLE_SYNC_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PQAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PQAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pqas_pkg.sv
// Types and constants of the PWM and quadrature angle sync core.
package pqas_pkg;

	localparam int ACTION_W = 2;
	localparam int CHAN_W   = 2;
	localparam int RAW_W    = 20;
	localparam int QUAD_W   = 32;
	localparam int ANGLE_W  = 16;
	localparam int ACC_W    = 16;
	localparam int WAIT_W   = 4;
	localparam int OVH_W    = 4;
	localparam int QLOW_W   = 12;
	localparam int CNT_W    = 21;
	localparam int SUM_W    = 22;
	localparam int REM_W    = 23;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 20;

	localparam logic [ACTION_W-1:0] ACT_MEAS   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SYNCED = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RAW    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERIOD = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_ACC = 8'd3;

	localparam logic [RAW_W-1:0]  RST_MAX_PERIOD  = 20'd312500;
	localparam logic [OVH_W-1:0]  RST_OVERHEAD    = 4'd3;
	localparam logic [WAIT_W-1:0] RST_FIRST_WAIT  = 4'd10;
	localparam logic [ACC_W-1:0]  RST_ACCURACY    = 16'd10000;
	localparam logic [WAIT_W-1:0] RST_WAIT_LEFT   = 4'd3;

	typedef struct packed {
		logic capture;
		logic count;
		logic update;
		logic div_step;
		logic finish;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic needs_div;
		logic out_free;
	} sts_t;

endpackage

### hdl/pqas_ifs.sv
// Handshake interfaces for items, results and configuration writes.
interface pqas_item_if;
	logic valid;
	logic ready;
	logic [pqas_pkg::ACTION_W-1:0] action;
	logic [pqas_pkg::CHAN_W-1:0] channel;
	logic [pqas_pkg::RAW_W-1:0] high_raw;
	logic [pqas_pkg::RAW_W-1:0] low_raw;
	logic signed [pqas_pkg::QUAD_W-1:0] quad_count;
	modport source (output valid, action, channel, high_raw, low_raw, quad_count,
		input ready);
	modport sink (input valid, action, channel, high_raw, low_raw, quad_count,
		output ready);
endinterface

interface pqas_res_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic [pqas_pkg::ANGLE_W-1:0] angle_frac;
	logic [pqas_pkg::ACC_W-1:0] accuracy_counts;
	logic synced;
	modport source (output valid, valid_res, angle_frac, accuracy_counts, synced,
		input ready);
	modport sink (input valid, valid_res, angle_frac, accuracy_counts, synced,
		output ready);
endinterface

interface pqas_cfg_if;
	logic valid;
	logic ready;
	logic [pqas_pkg::CFG_IDX_W-1:0] index;
	logic [pqas_pkg::CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/pqas_ctrl.sv
// Sequencing state machine of the angle sync core.
module pqas_ctrl #(
	parameter int ANGLE_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  pqas_pkg::sts_t  sts,
	output pqas_pkg::cmd_t  cmd
);

	localparam int DCW = $clog2(ANGLE_BITS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CNT  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0] state_q, state_d;
	logic [DCW-1:0] step_q, step_d;

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		cmd = '0;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_CNT;
				end
			end
			ST_CNT: begin
				cmd.count = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				step_d = '0;
				state_d = sts.needs_div ? ST_DIV : ST_DONE;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == DCW'(ANGLE_BITS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
		end
	end

endmodule

### hdl/pqas_dp.sv
// Datapath: channel state, period counts, duty divider and result register.
module pqas_dp #(
	parameter int CHANNELS   = 4,
	parameter int ANGLE_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [pqas_pkg::ACTION_W-1:0] action,
	input  logic [pqas_pkg::CHAN_W-1:0] channel,
	input  logic [pqas_pkg::RAW_W-1:0] high_raw,
	input  logic [pqas_pkg::RAW_W-1:0] low_raw,
	input  logic signed [pqas_pkg::QUAD_W-1:0] quad_count,
	input  pqas_pkg::cmd_t cmd,
	output pqas_pkg::sts_t sts,
	pqas_res_if.source res,
	pqas_cfg_if.sink cfg
);

	localparam int CH_IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AB = ANGLE_BITS;

	logic [pqas_pkg::RAW_W-1:0] max_period_q;
	logic [pqas_pkg::OVH_W-1:0] overhead_q;
	logic [pqas_pkg::WAIT_W-1:0] first_wait_q;
	logic [pqas_pkg::ACC_W-1:0] unknown_acc_q;

	logic armed_q [CHANNELS];
	logic [pqas_pkg::QUAD_W-1:0] prev_quad_q [CHANNELS];
	logic [pqas_pkg::WAIT_W-1:0] wait_left_q [CHANNELS];
	logic [pqas_pkg::ACC_W-1:0] acc_q [CHANNELS];
	logic [pqas_pkg::RAW_W-1:0] sync_high_q [CHANNELS];
	logic [pqas_pkg::RAW_W-1:0] sync_low_q [CHANNELS];
	logic [pqas_pkg::QLOW_W-1:0] sync_qlow_q [CHANNELS];
	logic [pqas_pkg::RAW_W-1:0] latest_high_q [CHANNELS];
	logic [pqas_pkg::RAW_W-1:0] latest_low_q [CHANNELS];

	logic [pqas_pkg::ACTION_W-1:0] act_q;
	logic [pqas_pkg::CHAN_W-1:0] ch_q;
	logic [pqas_pkg::RAW_W-1:0] hi_q, lo_q;
	logic [pqas_pkg::QUAD_W-1:0] quad_q;
	logic [pqas_pkg::CNT_W-1:0] c1_q, c2_q;
	logic [pqas_pkg::QUAD_W-1:0] dq_q;
	logic res_ok_q;
	logic [pqas_pkg::REM_W-1:0] rem_q;
	logic [pqas_pkg::SUM_W-1:0] den_q;
	logic [AB-1:0] quot_q, angle_q;

	logic out_valid_q;
	logic out_valid_res_q, out_synced_q;
	logic [pqas_pkg::ANGLE_W-1:0] out_angle_q;
	logic [pqas_pkg::ACC_W-1:0] out_acc_q;

	logic [CH_IW-1:0] idx;
	logic ch_ok;
	logic [pqas_pkg::RAW_W-1:0] sel_hi, sel_lo;
	logic cnt_ok;
	logic [pqas_pkg::QUAD_W-1:0] delta;
	logic acc_hit;
	logic [pqas_pkg::REM_W-1:0] rem_sh;
	logic rem_ge;
	logic [pqas_pkg::QLOW_W-1:0] qdiff;

	function automatic logic [pqas_pkg::CNT_W-1:0] period_count(
		input logic [pqas_pkg::RAW_W-1:0] raw,
		input logic [pqas_pkg::RAW_W-1:0] max_p,
		input logic [pqas_pkg::OVH_W-1:0] ovh
	);
		logic [pqas_pkg::CNT_W-1:0] top;
		logic [pqas_pkg::CNT_W-1:0] raw_x;
		top = {1'b0, max_p} + pqas_pkg::CNT_W'(ovh);
		raw_x = {1'b0, raw};
		if (raw == '0 || raw_x >= top) begin
			return '0;
		end
		return top - raw_x;
	endfunction

	assign idx = CH_IW'(ch_q);
	assign ch_ok = (32'(ch_q) < 32'(CHANNELS));

	always_comb begin
		case (act_q)
			pqas_pkg::ACT_SYNCED: begin
				sel_hi = sync_high_q[idx];
				sel_lo = sync_low_q[idx];
			end
			pqas_pkg::ACT_RAW: begin
				sel_hi = latest_high_q[idx];
				sel_lo = latest_low_q[idx];
			end
			default: begin
				sel_hi = hi_q;
				sel_lo = lo_q;
			end
		endcase
	end

	assign cnt_ok = (c1_q != '0) && (c2_q != '0);
	assign delta = dq_q[pqas_pkg::QUAD_W-1] ? (-dq_q) : dq_q;
	assign acc_hit = (delta <= pqas_pkg::QUAD_W'(acc_q[idx]));
	assign rem_sh = {rem_q[pqas_pkg::REM_W-2:0], 1'b0};
	assign rem_ge = (rem_sh >= pqas_pkg::REM_W'(den_q));
	assign qdiff = quad_q[pqas_pkg::QLOW_W-1:0] - sync_qlow_q[idx];

	assign sts.needs_div = ch_ok && cnt_ok &&
		((act_q == pqas_pkg::ACT_RAW) || ((act_q == pqas_pkg::ACT_SYNCED) && armed_q[idx]));
	assign sts.out_free = !out_valid_q || res.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_period_q <= pqas_pkg::RST_MAX_PERIOD;
			overhead_q <= pqas_pkg::RST_OVERHEAD;
			first_wait_q <= pqas_pkg::RST_FIRST_WAIT;
			unknown_acc_q <= pqas_pkg::RST_ACCURACY;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				pqas_pkg::CFG_MAX_PERIOD: max_period_q <= cfg.data;
				pqas_pkg::CFG_OVERHEAD: overhead_q <= cfg.data[pqas_pkg::OVH_W-1:0];
				pqas_pkg::CFG_FIRST_WAIT: first_wait_q <= cfg.data[pqas_pkg::WAIT_W-1:0];
				pqas_pkg::CFG_UNKNOWN_ACC: unknown_acc_q <= cfg.data[pqas_pkg::ACC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				armed_q[i] <= 1'b0;
				prev_quad_q[i] <= '0;
				wait_left_q[i] <= pqas_pkg::RST_WAIT_LEFT;
				acc_q[i] <= pqas_pkg::RST_ACCURACY;
				sync_high_q[i] <= '0;
				sync_low_q[i] <= '0;
				sync_qlow_q[i] <= '0;
				latest_high_q[i] <= '0;
				latest_low_q[i] <= '0;
			end
		end else if (cmd.update && ch_ok && act_q == pqas_pkg::ACT_MEAS) begin
			latest_high_q[idx] <= hi_q;
			latest_low_q[idx] <= lo_q;
			if (!cnt_ok) begin
				armed_q[idx] <= 1'b0;
				acc_q[idx] <= unknown_acc_q;
			end else if (!armed_q[idx]) begin
				armed_q[idx] <= 1'b1;
				prev_quad_q[idx] <= quad_q;
				wait_left_q[idx] <= first_wait_q;
			end else begin
				prev_quad_q[idx] <= quad_q;
				if (wait_left_q[idx] != '0) begin
					wait_left_q[idx] <= wait_left_q[idx] - 1'b1;
				end else if (acc_hit) begin
					sync_high_q[idx] <= hi_q;
					sync_low_q[idx] <= lo_q;
					sync_qlow_q[idx] <= quad_q[pqas_pkg::QLOW_W-1:0];
					acc_q[idx] <= delta[pqas_pkg::ACC_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			ch_q <= channel;
			hi_q <= high_raw;
			lo_q <= low_raw;
			quad_q <= quad_count;
		end
		if (cmd.count) begin
			c1_q <= period_count(sel_hi, max_period_q, overhead_q);
			c2_q <= period_count(sel_lo, max_period_q, overhead_q);
			dq_q <= quad_q - prev_quad_q[idx];
		end
		if (cmd.update) begin
			res_ok_q <= sts.needs_div;
			rem_q <= pqas_pkg::REM_W'(c1_q);
			den_q <= pqas_pkg::SUM_W'(c1_q) + pqas_pkg::SUM_W'(c2_q);
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? (rem_sh - pqas_pkg::REM_W'(den_q)) : rem_sh;
			quot_q <= {quot_q[AB-2:0], rem_ge};
		end
		if (cmd.finish) begin
			if (act_q == pqas_pkg::ACT_SYNCED) begin
				angle_q <= quot_q + (AB'(qdiff) << (AB - pqas_pkg::QLOW_W));
			end else begin
				angle_q <= quot_q;
			end
		end
		if (cmd.load) begin
			out_valid_res_q <= res_ok_q;
			out_angle_q <= res_ok_q ? pqas_pkg::ANGLE_W'(angle_q) : '0;
			out_acc_q <= ch_ok ? acc_q[idx] : '0;
			out_synced_q <= ch_ok ? armed_q[idx] : 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid = out_valid_q;
	assign res.valid_res = out_valid_res_q;
	assign res.angle_frac = out_angle_q;
	assign res.accuracy_counts = out_acc_q;
	assign res.synced = out_synced_q;

endmodule

### hdl/pwm_quadrature_angle_sync_core.sv
// Top level of the PWM and quadrature angle sync core.
// A query that needs the duty divider steps through the capture, count, update, divide,
// finish and done states; measurements, unused actions and invalid queries go from update to done.
// One item is in work at a time: the next beat is taken in the cycle after the result is
// registered, and a divided query runs the one-bit-a-cycle restoring divider over all
// ANGLE_BITS quotient bits. The done state waits until the output register is free.
// Reset is asynchronous and active low; it resets all channel state and loads the
// register defaults.
module pwm_quadrature_angle_sync_core #(
	parameter int CHANNELS   = 4,
	parameter int ANGLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	pqas_item_if.sink item,
	pqas_res_if.source res,
	pqas_cfg_if.sink cfg
);

	pqas_pkg::cmd_t cmd;
	pqas_pkg::sts_t sts;
	logic item_ready;

	assign item.ready = item_ready;

	pqas_ctrl #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item.valid),
		.item_ready(item_ready),
		.sts(sts),
		.cmd(cmd)
	);

	pqas_dp #(
		.CHANNELS(CHANNELS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.action(item.action),
		.channel(item.channel),
		.high_raw(item.high_raw),
		.low_raw(item.low_raw),
		.quad_count(item.quad_count),
		.cmd(cmd),
		.sts(sts),
		.res(res),
		.cfg(cfg)
	);

endmodule

### hdl/pqas_checker.sv
// Port-level checks of the angle sync core and their binding.
`include "pwm_quadrature_angle_sync_core_defines.svh"

module pqas_checker (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	input logic item_ready,
	input logic res_valid,
	input logic res_ready,
	input logic res_valid_res,
	input logic [15:0] res_angle
);

	`PQAS_ASSERT_NOW(a_zero_angle, res_valid && !res_valid_res, res_angle == 16'd0, "invalid result carries a nonzero angle")
	`PQAS_ASSERT_NEXT(a_one_in_work, item_valid && item_ready, !item_ready, "second beat taken while an item is in work")
	`PQAS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_angle), "stalled result beat changed")

endmodule

bind pwm_quadrature_angle_sync_core pqas_checker u_pqas_checker (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item.valid),
	.item_ready(item.ready),
	.res_valid(res.valid),
	.res_ready(res.ready),
	.res_valid_res(res.valid_res),
	.res_angle(res.angle_frac)
);

### tb/testbench.sv
// Self-checking testbench for the PWM and quadrature angle sync core.
module testbench;

	localparam int NCHAN = 4;
	localparam int LONG_HOLD = 400;
	localparam int HOLD_AT = 500;
	localparam logic [pqas_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [pqas_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 8'hFF;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [pqas_pkg::ACTION_W-1:0] action;
		logic [pqas_pkg::CHAN_W-1:0] channel;
		logic [pqas_pkg::RAW_W-1:0] high_raw;
		logic [pqas_pkg::RAW_W-1:0] low_raw;
		logic [pqas_pkg::QUAD_W-1:0] quad;
	} item_t;

	typedef struct packed {
		logic valid_res;
		logic [pqas_pkg::ANGLE_W-1:0] angle;
		logic [pqas_pkg::ACC_W-1:0] accuracy;
		logic synced;
	} angle_res_t;

	typedef struct packed {
		row_kind_t kind;
		item_t it;
		logic [pqas_pkg::CFG_IDX_W-1:0] idx;
		logic [pqas_pkg::CFG_DATA_W-1:0] data;
		logic typed;
		angle_res_t want;
	} step_row_t;

	logic clk;
	logic arst_n;

	pqas_item_if item_ch();
	pqas_res_if res_ch();
	pqas_cfg_if cfg_ch();

	pwm_quadrature_angle_sync_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	logic [pqas_pkg::RAW_W-1:0] cfg_period;
	logic [pqas_pkg::OVH_W-1:0] cfg_overhead;
	logic [pqas_pkg::WAIT_W-1:0] cfg_wait;
	logic [pqas_pkg::ACC_W-1:0] cfg_unknown;

	logic armed [NCHAN];
	logic [pqas_pkg::QUAD_W-1:0] last_quad [NCHAN];
	logic [pqas_pkg::WAIT_W-1:0] wait_cnt [NCHAN];
	logic [pqas_pkg::ACC_W-1:0] acc_cnt [NCHAN];
	logic [pqas_pkg::RAW_W-1:0] anchor_high [NCHAN];
	logic [pqas_pkg::RAW_W-1:0] anchor_low [NCHAN];
	logic [pqas_pkg::QLOW_W-1:0] anchor_qlow [NCHAN];
	logic [pqas_pkg::RAW_W-1:0] recent_high [NCHAN];
	logic [pqas_pkg::RAW_W-1:0] recent_low [NCHAN];

	angle_res_t pending_angles [$];
	step_row_t steps [$];

	int errors = 0;
	int items_sent = 0;
	int taken = 0;
	int sync_updates = 0;
	int reg_writes = 0;
	bit calm = 0;
	bit item_up = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6000000;
		$display("testbench: done, errors");
		$finish;
	end

	function automatic logic [31:0] period_ticks(logic [pqas_pkg::RAW_W-1:0] raw);
		logic [31:0] top;
		top = 32'(cfg_period) + 32'(cfg_overhead);
		if (raw == 0 || 32'(raw) >= top)
			return 32'd0;
		return top - 32'(raw);
	endfunction

	function automatic bit duty_fraction(logic [pqas_pkg::RAW_W-1:0] hi,
		logic [pqas_pkg::RAW_W-1:0] lo, output logic [31:0] frac);
		logic [63:0] c1;
		logic [63:0] c2;
		c1 = 64'(period_ticks(hi));
		c2 = 64'(period_ticks(lo));
		frac = 32'd0;
		if (c1 == 0 || c2 == 0)
			return 1'b0;
		frac = 32'((c1 << pqas_pkg::ANGLE_W) / (c1 + c2));
		return 1'b1;
	endfunction

	function automatic angle_res_t predict_angle(item_t it);
		angle_res_t r;
		logic [31:0] base;
		logic [31:0] delta;
		int unsigned ch;
		r = '0;
		ch = it.channel;
		case (it.action)
			pqas_pkg::ACT_MEAS: begin
				recent_high[ch] = it.high_raw;
				recent_low[ch] = it.low_raw;
				if (period_ticks(it.high_raw) == 0 || period_ticks(it.low_raw) == 0) begin
					armed[ch] = 1'b0;
					acc_cnt[ch] = cfg_unknown;
				end else if (!armed[ch]) begin
					armed[ch] = 1'b1;
					last_quad[ch] = it.quad;
					wait_cnt[ch] = cfg_wait;
				end else begin
					delta = it.quad - last_quad[ch];
					if (delta[31])
						delta = -delta;
					last_quad[ch] = it.quad;
					if (wait_cnt[ch] != 0) begin
						wait_cnt[ch] = wait_cnt[ch] - 1'b1;
					end else if (delta <= {16'd0, acc_cnt[ch]}) begin
						anchor_high[ch] = it.high_raw;
						anchor_low[ch] = it.low_raw;
						anchor_qlow[ch] = it.quad[pqas_pkg::QLOW_W-1:0];
						acc_cnt[ch] = delta[pqas_pkg::ACC_W-1:0];
						sync_updates++;
					end
				end
			end
			pqas_pkg::ACT_SYNCED: begin
				if (armed[ch] && duty_fraction(anchor_high[ch], anchor_low[ch], base)) begin
					r.valid_res = 1'b1;
					r.angle = base[pqas_pkg::ANGLE_W-1:0]
						+ {it.quad[pqas_pkg::QLOW_W-1:0] - anchor_qlow[ch], 4'd0};
				end
			end
			pqas_pkg::ACT_RAW: begin
				if (duty_fraction(recent_high[ch], recent_low[ch], base)) begin
					r.valid_res = 1'b1;
					r.angle = base[pqas_pkg::ANGLE_W-1:0];
				end
			end
			default: ;
		endcase
		r.accuracy = acc_cnt[ch];
		r.synced = armed[ch];
		return r;
	endfunction

	function automatic void set_register(logic [pqas_pkg::CFG_IDX_W-1:0] idx,
		logic [pqas_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			pqas_pkg::CFG_MAX_PERIOD: cfg_period = val[pqas_pkg::RAW_W-1:0];
			pqas_pkg::CFG_OVERHEAD: cfg_overhead = val[pqas_pkg::OVH_W-1:0];
			pqas_pkg::CFG_FIRST_WAIT: cfg_wait = val[pqas_pkg::WAIT_W-1:0];
			pqas_pkg::CFG_UNKNOWN_ACC: cfg_unknown = val[pqas_pkg::ACC_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [pqas_pkg::RAW_W-1:0] pick_raw();
		logic [31:0] top;
		top = 32'(cfg_period) + 32'(cfg_overhead);
		case ($urandom_range(0, 23))
			0: return '0;
			1: return '1;
			2: return (top > 32'hFFFFF) ? '1 : top[pqas_pkg::RAW_W-1:0];
			3: return pqas_pkg::RAW_W'($urandom());
			4: return pqas_pkg::RAW_W'(1);
			default: begin
				if (top < 2)
					return pqas_pkg::RAW_W'($urandom());
				return pqas_pkg::RAW_W'($urandom_range(1,
					(top > 32'h100000) ? 32'hFFFFF : top - 1));
			end
		endcase
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic void add_cfg(logic [pqas_pkg::CFG_IDX_W-1:0] idx,
		logic [pqas_pkg::CFG_DATA_W-1:0] val);
		step_row_t row;
		row = '0;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = val;
		steps.push_back(row);
	endfunction

	function automatic void add_item(logic [pqas_pkg::ACTION_W-1:0] act,
		logic [pqas_pkg::CHAN_W-1:0] ch, logic [pqas_pkg::RAW_W-1:0] hi,
		logic [pqas_pkg::RAW_W-1:0] lo, logic [pqas_pkg::QUAD_W-1:0] quad);
		step_row_t row;
		row = '0;
		row.kind = ROW_ITEM;
		row.it = '{act, ch, hi, lo, quad};
		steps.push_back(row);
	endfunction

	function automatic void add_known(logic [pqas_pkg::ACTION_W-1:0] act,
		logic [pqas_pkg::CHAN_W-1:0] ch, logic [pqas_pkg::RAW_W-1:0] hi,
		logic [pqas_pkg::RAW_W-1:0] lo, logic [pqas_pkg::QUAD_W-1:0] quad,
		logic v, logic [pqas_pkg::ANGLE_W-1:0] ang, logic [pqas_pkg::ACC_W-1:0] acc,
		logic syn);
		step_row_t row;
		add_item(act, ch, hi, lo, quad);
		row = steps.pop_back();
		row.typed = 1'b1;
		row.want = '{v, ang, acc, syn};
		steps.push_back(row);
	endfunction

	task automatic send_item(item_t it, logic typed, angle_res_t want);
		angle_res_t model;
		int unsigned gap;
		item_ch.action <= it.action;
		item_ch.channel <= it.channel;
		item_ch.high_raw <= it.high_raw;
		item_ch.low_raw <= it.low_raw;
		item_ch.quad_count <= it.quad;
		item_ch.valid <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		model = predict_angle(it);
		pending_angles.push_back(typed ? want : model);
		items_sent++;
		gap = calm ? 0 : $urandom_range(0, 7);
		item_up = (gap == 0);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		if (item_up) begin
			item_ch.valid <= 1'b0;
			item_up = 1'b0;
		end
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [pqas_pkg::CFG_IDX_W-1:0] idx,
		logic [pqas_pkg::CFG_DATA_W-1:0] val);
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		set_register(idx, val);
		reg_writes++;
		@(posedge clk);
	endtask

	// The result side stalls at random, holds off once for a long stretch and checks beats in order.
	initial begin
		int unsigned gap;
		angle_res_t want;
		res_ch.ready = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			gap = (taken == HOLD_AT) ? LONG_HOLD : (calm ? 0 : $urandom_range(0, 7));
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			taken++;
			if (pending_angles.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat, expected none, got valid_res %0d angle %0d",
					$time, res_ch.valid_res, res_ch.angle_frac);
			end else begin
				want = pending_angles.pop_front();
				check_field("valid_res", 32'(want.valid_res), 32'(res_ch.valid_res));
				check_field("angle_frac", 32'(want.angle), 32'(res_ch.angle_frac));
				check_field("accuracy_counts", 32'(want.accuracy),
					32'(res_ch.accuracy_counts));
				check_field("synced", 32'(want.synced), 32'(res_ch.synced));
			end
		end
	end

	initial begin
		item_t it;
		int unsigned r;
		int unsigned ch;
		int unsigned count;
		logic [pqas_pkg::QUAD_W-1:0] quad_now [NCHAN];
		logic [pqas_pkg::RAW_W-1:0] period;
		logic [pqas_pkg::OVH_W-1:0] ovh;
		logic [pqas_pkg::WAIT_W-1:0] wt;
		logic [pqas_pkg::ACC_W-1:0] unk;

		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.action = pqas_pkg::ACT_MEAS;
		item_ch.channel = '0;
		item_ch.high_raw = '0;
		item_ch.low_raw = '0;
		item_ch.quad_count = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = pqas_pkg::CFG_MAX_PERIOD;
		cfg_ch.data = '0;
		cfg_period = pqas_pkg::RST_MAX_PERIOD;
		cfg_overhead = pqas_pkg::RST_OVERHEAD;
		cfg_wait = pqas_pkg::RST_FIRST_WAIT;
		cfg_unknown = pqas_pkg::RST_ACCURACY;
		for (int c = 0; c < NCHAN; c++) begin
			armed[c] = 1'b0;
			last_quad[c] = '0;
			wait_cnt[c] = pqas_pkg::RST_WAIT_LEFT;
			acc_cnt[c] = pqas_pkg::RST_ACCURACY;
			anchor_high[c] = '0;
			anchor_low[c] = '0;
			anchor_qlow[c] = '0;
			recent_high[c] = '0;
			recent_low[c] = '0;
			quad_now[c] = '0;
		end

		add_known(pqas_pkg::ACT_RAW, 2'd0, 20'd0, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b0);
		add_known(pqas_pkg::ACT_SYNCED, 2'd1, 20'd0, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b0);
		add_known(ACT_UNUSED, 2'd2, 20'hFFFFF, 20'hFFFFF, 32'hFFFFFFFF,
			1'b0, 16'd0, 16'd10000, 1'b0);
		add_known(pqas_pkg::ACT_MEAS, 2'd0, 20'd0, 20'd1000, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b0);
		add_known(pqas_pkg::ACT_MEAS, 2'd0, 20'd312503, 20'd1000, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b0);
		add_known(pqas_pkg::ACT_MEAS, 2'd0, 20'd312502, 20'd312502, 32'h7FFFFFFF,
			1'b0, 16'd0, 16'd10000, 1'b1);
		add_known(pqas_pkg::ACT_RAW, 2'd0, 20'd0, 20'd0, 32'd0,
			1'b1, 16'd32768, 16'd10000, 1'b1);
		add_known(pqas_pkg::ACT_SYNCED, 2'd0, 20'd0, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b1);
		add_cfg(pqas_pkg::CFG_FIRST_WAIT, 20'd0);
		add_known(pqas_pkg::ACT_MEAS, 2'd1, 20'd100, 20'd200, 32'h7FFFFFFF,
			1'b0, 16'd0, 16'd10000, 1'b1);
		add_item(pqas_pkg::ACT_MEAS, 2'd1, 20'd100, 20'd200, 32'h80000000);
		add_item(pqas_pkg::ACT_SYNCED, 2'd1, 20'd0, 20'd0, 32'hFFFFFFFF);
		add_item(pqas_pkg::ACT_MEAS, 2'd1, 20'd312502, 20'd1, 32'h00000000);
		add_cfg(pqas_pkg::CFG_UNKNOWN_ACC, 20'd65535);
		add_known(pqas_pkg::ACT_MEAS, 2'd2, 20'd5, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd65535, 1'b0);
		add_cfg(pqas_pkg::CFG_UNKNOWN_ACC, 20'd0);
		add_known(pqas_pkg::ACT_MEAS, 2'd1, 20'd100, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd0, 1'b0);
		add_known(pqas_pkg::ACT_SYNCED, 2'd1, 20'd0, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd0, 1'b0);
		add_known(pqas_pkg::ACT_MEAS, 2'd1, 20'd100, 20'd200, 32'd5,
			1'b0, 16'd0, 16'd0, 1'b1);
		add_item(pqas_pkg::ACT_SYNCED, 2'd1, 20'd0, 20'd0, 32'd123);
		add_cfg(pqas_pkg::CFG_MAX_PERIOD, 20'hFFFFF);
		add_cfg(pqas_pkg::CFG_OVERHEAD, 20'hABCDF);
		add_item(pqas_pkg::ACT_MEAS, 2'd3, 20'hFFFFF, 20'd1, 32'd0);
		add_item(pqas_pkg::ACT_RAW, 2'd3, 20'd0, 20'd0, 32'd0);
		add_cfg(CFG_SPARE_IDX, 20'h5A5A5);
		add_cfg(pqas_pkg::CFG_MAX_PERIOD, 20'd1);
		add_cfg(pqas_pkg::CFG_OVERHEAD, 20'd0);
		add_known(pqas_pkg::ACT_RAW, 2'd3, 20'd0, 20'd0, 32'd0,
			1'b0, 16'd0, 16'd10000, 1'b1);
		add_known(pqas_pkg::ACT_MEAS, 2'd3, 20'd1, 20'd1, 32'd0,
			1'b0, 16'd0, 16'd0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG) begin
				settle();
				write_reg(steps[i].idx, steps[i].data);
			end else begin
				send_item(steps[i].it, steps[i].typed, steps[i].want);
			end
		end

		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					period = pqas_pkg::RST_MAX_PERIOD;
					ovh = pqas_pkg::RST_OVERHEAD;
					wt = pqas_pkg::RST_FIRST_WAIT;
					unk = pqas_pkg::RST_ACCURACY;
				end
				1: begin
					period = 20'd1;
					ovh = 4'd0;
					wt = 4'd0;
					unk = 16'd0;
				end
				2: begin
					period = 20'hFFFFF;
					ovh = 4'd15;
					wt = 4'd15;
					unk = 16'hFFFF;
				end
				3: begin
					period = 20'd1;
					ovh = 4'd15;
					wt = 4'd0;
					unk = 16'd0;
				end
				4: begin
					period = 20'd1000;
					ovh = 4'd0;
					wt = 4'd1;
					unk = 16'd100;
				end
				default: begin
					period = pqas_pkg::RAW_W'($urandom_range(2,
						(1 << $urandom_range(2, 20)) - 1));
					ovh = pqas_pkg::OVH_W'($urandom());
					wt = pqas_pkg::WAIT_W'($urandom_range(0, 4));
					unk = pqas_pkg::ACC_W'($urandom());
				end
			endcase
			settle();
			write_reg(pqas_pkg::CFG_MAX_PERIOD, period);
			write_reg(pqas_pkg::CFG_OVERHEAD, {16'($urandom()), ovh});
			write_reg(pqas_pkg::CFG_FIRST_WAIT, {16'($urandom()), wt});
			write_reg(pqas_pkg::CFG_UNKNOWN_ACC, {4'($urandom()), unk});

			count = (phase == 1) ? 40 : 180;
			for (int n = 0; n < count; n++) begin
				if (n % 40 == 0)
					calm = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				ch = $urandom_range(0, NCHAN - 1);
				it.channel = pqas_pkg::CHAN_W'(ch);
				it.high_raw = pqas_pkg::RAW_W'($urandom());
				it.low_raw = pqas_pkg::RAW_W'($urandom());
				it.quad = $urandom();
				if (r < 52) begin
					it.action = pqas_pkg::ACT_MEAS;
					case ($urandom_range(0, 15))
						0: quad_now[ch] = $urandom();
						1: quad_now[ch] = quad_now[ch] + 32'h80000000;
						2, 3: quad_now[ch] = quad_now[ch] + $urandom_range(0, 40) - 20;
						default: quad_now[ch] = quad_now[ch] + $urandom_range(0, 4) - 2;
					endcase
					it.quad = quad_now[ch];
					it.high_raw = pick_raw();
					it.low_raw = pick_raw();
				end else if (r < 95) begin
					it.action = (r < 75) ? pqas_pkg::ACT_SYNCED : pqas_pkg::ACT_RAW;
					if ($urandom_range(0, 3) != 0)
						it.quad = quad_now[ch] + $urandom_range(0, 4095);
				end else begin
					it.action = ACT_UNUSED;
				end
				send_item(it, 1'b0, '0);
			end
		end
		calm = 1'b0;

		settle();
		repeat (30) @(posedge clk);
		$display("Run covered %0d items and %0d results across %0d register writes.",
			items_sent, taken, reg_writes);
		$display("The model took %0d sync points; results were held off for %0d cycles once.",
			sync_updates, LONG_HOLD);
		if (errors == 0 && pending_angles.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/pqas_pkg.sv
hdl/pqas_ifs.sv
hdl/pqas_ctrl.sv
hdl/pqas_dp.sv
hdl/pwm_quadrature_angle_sync_core.sv
hdl/pqas_checker.sv
tb/testbench.sv
